FILE: rtl/core/i2cwm_pkg.sv
// ----------------------------------------------------------------------------
// i2cwm_pkg: shared types and codes of the write-only I2C master
// Item and result records, function codes, register indexes and the
// phase encoding of the bit-bang sequencer.
// ----------------------------------------------------------------------------
package i2cwm_pkg;

	typedef enum logic [1:0] {
		FUNC_TICK   = 2'd0,
		FUNC_BEGIN3 = 2'd1,
		FUNC_BEGIN4 = 2'd2,
		FUNC_RSVD   = 2'd3
	} func_t;

	localparam logic REG_DEVICE_ADDRESS   = 1'b0;
	localparam logic REG_ACK_SAMPLE_LIMIT = 1'b1;

	localparam logic [7:0] DEVICE_ADDRESS_RST   = 8'h70;
	localparam logic [3:0] ACK_SAMPLE_LIMIT_RST = 4'd5;

	typedef enum logic [4:0] {
		PH_IDLE     = 5'd0,
		PH_DUMMY0   = 5'd1,
		PH_DUMMY1   = 5'd2,
		PH_DUMMY2   = 5'd3,
		PH_DUMMY3   = 5'd4,
		PH_START0   = 5'd5,
		PH_START1   = 5'd6,
		PH_START2   = 5'd7,
		PH_START3   = 5'd8,
		PH_BIT_SET  = 5'd9,
		PH_BIT_HIGH = 5'd10,
		PH_BIT_LOW  = 5'd11,
		PH_ACK_REL  = 5'd12,
		PH_ACK_SMP  = 5'd13,
		PH_ACK_HOLD = 5'd14,
		PH_STOP0    = 5'd15,
		PH_STOP1    = 5'd16,
		PH_STOP2    = 5'd17,
		PH_STOP3    = 5'd18
	} phase_t;

	typedef struct packed {
		func_t      func;
		logic [7:0] command_byte;
		logic [7:0] register_address;
		logic [7:0] data_byte;
		logic       sda_sample;
	} item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive_enable;
		logic       busy_res;
		logic       done_res;
		logic [3:0] ack_missed_mask;
	} result_t;

endpackage

FILE: rtl/core/i2cwm_if.sv
// ----------------------------------------------------------------------------
// i2cwm_if: valid/ready channels of the I2C write master
// Input channel carries one item per beat, output channel one result.
// ----------------------------------------------------------------------------
interface i2cwm_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] command_byte;
	logic [7:0] register_address;
	logic [7:0] data_byte;
	logic       sda_sample;

	modport source (
		output valid, func, command_byte, register_address, data_byte, sda_sample,
		input  ready
	);
	modport sink (
		input  valid, func, command_byte, register_address, data_byte, sda_sample,
		output ready
	);
endinterface

interface i2cwm_out_if;
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_level;
	logic       sda_drive_enable;
	logic       busy_res;
	logic       done_res;
	logic [3:0] ack_missed_mask;

	modport source (
		output valid, scl_level, sda_level, sda_drive_enable, busy_res, done_res,
		       ack_missed_mask,
		input  ready
	);
	modport sink (
		input  valid, scl_level, sda_level, sda_drive_enable, busy_res, done_res,
		       ack_missed_mask,
		output ready
	);
endinterface

FILE: rtl/core/i2c_write_master_unit.sv
// ----------------------------------------------------------------------------
// i2c_write_master_unit: write-only bit-bang I2C master
// Path: each input beat passes the input register, then the result register.
// Throughput: one item per cycle unless the output stalls; the phase sequencer
// takes one step per item and advances at most one phase on that step.
// The result register is fed again in the same cycle it is taken, so no bubbles.
// Reset: sequencer idle, mask cleared, device_address 0x70, ack_sample_limit 5.
// ----------------------------------------------------------------------------
module i2c_write_master_unit (
	input  logic        clk,
	input  logic        arst_n,
	i2cwm_in_if.sink    in_ch,
	i2cwm_out_if.source out_ch,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);

	logic               valid_s1;
	i2cwm_pkg::item_t   item_s1;
	logic               out_valid_q;
	i2cwm_pkg::result_t result_q;
	i2cwm_pkg::result_t result_d;
	logic [7:0]         device_address_q;
	logic [3:0]         ack_sample_limit_q;
	logic               advance;
	logic               in_beat;

	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;
	assign in_beat     = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q   <= i2cwm_pkg::DEVICE_ADDRESS_RST;
			ack_sample_limit_q <= i2cwm_pkg::ACK_SAMPLE_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				i2cwm_pkg::REG_DEVICE_ADDRESS:   device_address_q   <= cfg_data;
				i2cwm_pkg::REG_ACK_SAMPLE_LIMIT: ack_sample_limit_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			item_s1.func             <= i2cwm_pkg::func_t'(in_ch.func);
			item_s1.command_byte     <= in_ch.command_byte;
			item_s1.register_address <= in_ch.register_address;
			item_s1.data_byte        <= in_ch.data_byte;
			item_s1.sda_sample       <= in_ch.sda_sample;
		end
	end

	i2cwm_seq u_seq (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (advance),
		.item             (item_s1),
		.device_address   (device_address_q),
		.ack_sample_limit (ack_sample_limit_q),
		.result           (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.scl_level        = result_q.scl_level;
	assign out_ch.sda_level        = result_q.sda_level;
	assign out_ch.sda_drive_enable = result_q.sda_drive_enable;
	assign out_ch.busy_res         = result_q.busy_res;
	assign out_ch.done_res         = result_q.done_res;
	assign out_ch.ack_missed_mask  = result_q.ack_missed_mask;

	// a processed beat always lands in the result register
	a_advance_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("processed beat did not reach result register");

	// an empty result register never blocks the input side
	a_empty_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ch.ready)
		else $error("input stalled with empty result register");

	// the stop slot ends the transfer
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && result_q.done_res) |-> !result_q.busy_res)
		else $error("done reported while still busy");

	// SDA is only released inside a running transfer
	a_release_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result_q.sda_drive_enable) |-> result_q.busy_res)
		else $error("SDA released outside a transfer");

endmodule

FILE: rtl/core/i2cwm_seq.sv
// ----------------------------------------------------------------------------
// i2cwm_seq: bit-bang phase sequencer
// Holds the transfer state, advances at most one phase per step and forms the
// line levels and status of that step.
// ----------------------------------------------------------------------------
module i2cwm_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  i2cwm_pkg::item_t  item,
	input  logic [7:0]        device_address,
	input  logic [3:0]        ack_sample_limit,
	output i2cwm_pkg::result_t result
);

	i2cwm_pkg::phase_t phase_q, phase_d;
	logic [3:0] bit_count_q, bit_count_d;
	logic [2:0] byte_index_q, byte_index_d;
	logic [7:0] shift_q, shift_d;
	logic       four_byte_q, four_byte_d;
	logic [3:0] ack_wait_q, ack_wait_d;
	logic [3:0] missed_q, missed_d;
	logic       done;
	logic       busy;
	logic       load_begin;
	logic [7:0] byte_store [4];
	logic [3:0] lim;
	logic [3:0] wait_inc;
	logic [1:0] last_idx;
	logic [2:0] load_idx;
	logic       scl, sda, oe;

	assign busy       = (phase_q != i2cwm_pkg::PH_IDLE);
	assign load_begin = !busy && (item.func == i2cwm_pkg::FUNC_BEGIN3 ||
		item.func == i2cwm_pkg::FUNC_BEGIN4);
	assign lim        = (ack_sample_limit == 4'd0) ? 4'd1 : ack_sample_limit;
	assign wait_inc   = ack_wait_q + 4'd1;
	assign last_idx   = four_byte_q ? 2'd3 : 2'd2;
	assign load_idx   = (phase_q == i2cwm_pkg::PH_ACK_HOLD) ? byte_index_q + 3'd1 : 3'd0;

	// next state
	always_comb begin
		phase_d      = phase_q;
		bit_count_d  = bit_count_q;
		byte_index_d = byte_index_q;
		shift_d      = shift_q;
		four_byte_d  = four_byte_q;
		ack_wait_d   = ack_wait_q;
		missed_d     = missed_q;
		done         = 1'b0;
		if (load_begin) begin
			four_byte_d  = (item.func == i2cwm_pkg::FUNC_BEGIN4);
			missed_d     = 4'd0;
			bit_count_d  = 4'd0;
			byte_index_d = 3'd0;
			ack_wait_d   = 4'd0;
			phase_d      = i2cwm_pkg::PH_DUMMY0;
		end else if (busy && item.func != i2cwm_pkg::FUNC_RSVD) begin
			case (phase_q)
				i2cwm_pkg::PH_START3: begin
					byte_index_d = load_idx;
					shift_d      = byte_store[load_idx[1:0]];
					bit_count_d  = 4'd0;
					phase_d      = i2cwm_pkg::PH_BIT_SET;
				end
				i2cwm_pkg::PH_BIT_LOW: begin
					shift_d     = {shift_q[6:0], 1'b0};
					bit_count_d = bit_count_q + 4'd1;
					phase_d     = (bit_count_d >= 4'd8) ? i2cwm_pkg::PH_ACK_REL
						: i2cwm_pkg::PH_BIT_SET;
				end
				i2cwm_pkg::PH_ACK_REL: begin
					ack_wait_d = 4'd0;
					phase_d    = i2cwm_pkg::PH_ACK_SMP;
				end
				i2cwm_pkg::PH_ACK_SMP: begin
					ack_wait_d = wait_inc;
					if (!item.sda_sample) begin
						phase_d = i2cwm_pkg::PH_ACK_HOLD;
					end else if (wait_inc >= lim || wait_inc == 4'd0) begin
						missed_d = missed_q | (4'd1 << byte_index_q[1:0]);
						phase_d  = i2cwm_pkg::PH_ACK_HOLD;
					end
				end
				i2cwm_pkg::PH_ACK_HOLD: begin
					if (byte_index_q >= {1'b0, last_idx}) begin
						phase_d = i2cwm_pkg::PH_STOP0;
					end else begin
						byte_index_d = load_idx;
						shift_d      = byte_store[load_idx[1:0]];
						bit_count_d  = 4'd0;
						phase_d      = i2cwm_pkg::PH_BIT_SET;
					end
				end
				i2cwm_pkg::PH_STOP3: begin
					phase_d = i2cwm_pkg::PH_IDLE;
					done    = 1'b1;
				end
				default: begin
					phase_d = i2cwm_pkg::phase_t'(phase_q + 5'd1);
				end
			endcase
		end
	end

	// line levels of the current phase
	always_comb begin
		scl = 1'b1;
		sda = 1'b1;
		oe  = 1'b1;
		case (phase_q)
			i2cwm_pkg::PH_DUMMY3:   scl = 1'b0;
			i2cwm_pkg::PH_START0:   scl = 1'b0;
			i2cwm_pkg::PH_START2:   sda = 1'b0;
			i2cwm_pkg::PH_START3: begin
				scl = 1'b0;
				sda = 1'b0;
			end
			i2cwm_pkg::PH_BIT_SET: begin
				scl = 1'b0;
				sda = shift_q[7];
			end
			i2cwm_pkg::PH_BIT_HIGH: sda = shift_q[7];
			i2cwm_pkg::PH_BIT_LOW: begin
				scl = 1'b0;
				sda = shift_q[7];
			end
			i2cwm_pkg::PH_ACK_REL: begin
				scl = 1'b0;
				oe  = 1'b0;
			end
			i2cwm_pkg::PH_ACK_SMP:  oe = 1'b0;
			i2cwm_pkg::PH_ACK_HOLD: oe = 1'b0;
			i2cwm_pkg::PH_STOP0:    scl = 1'b0;
			i2cwm_pkg::PH_STOP1: begin
				scl = 1'b0;
				sda = 1'b0;
			end
			i2cwm_pkg::PH_STOP2:    sda = 1'b0;
			default: begin
				scl = 1'b1;
				sda = 1'b1;
				oe  = 1'b1;
			end
		endcase
	end

	assign result.scl_level        = scl;
	assign result.sda_level        = sda;
	assign result.sda_drive_enable = oe;
	assign result.busy_res         = (phase_d != i2cwm_pkg::PH_IDLE);
	assign result.done_res         = done;
	assign result.ack_missed_mask  = missed_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= i2cwm_pkg::PH_IDLE;
			bit_count_q  <= 4'd0;
			byte_index_q <= 3'd0;
			shift_q      <= 8'd0;
			four_byte_q  <= 1'b0;
			ack_wait_q   <= 4'd0;
			missed_q     <= 4'd0;
		end else if (step) begin
			phase_q      <= phase_d;
			bit_count_q  <= bit_count_d;
			byte_index_q <= byte_index_d;
			shift_q      <= shift_d;
			four_byte_q  <= four_byte_d;
			ack_wait_q   <= ack_wait_d;
			missed_q     <= missed_d;
		end
	end

	// transfer bytes; in three-byte mode the last entry is left unused
	always_ff @(posedge clk) begin
		if (step && load_begin) begin
			byte_store[0] <= device_address;
			byte_store[1] <= item.command_byte;
			if (item.func == i2cwm_pkg::FUNC_BEGIN4) begin
				byte_store[2] <= item.register_address;
				byte_store[3] <= item.data_byte;
			end else begin
				byte_store[2] <= item.data_byte;
			end
		end
	end

endmodule
